### rtl/core/pida_pkg.sv
// Package for the positional insert/delete list: sizes, operation and status
// codes, and the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package pida_pkg;

  // List capacity and field widths.
  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MODE_W = 2;
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 8;

  // Operation codes on the mode field.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decide;
    logic ptr_from_count;
    logic ptr_from_idx;
    logic rd_prev;
    logic rd_next;
    logic rd_idx;
    logic wr_shift;
    logic wr_value;
    logic ptr_dec;
    logic ptr_inc;
    logic cap_rv;
    logic cnt_inc;
    logic cnt_dec;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic err;
    logic is_insert;
    logic is_delete;
    logic ins_no_shift;
    logic ins_last;
    logic del_more;
    logic del_more_next;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/positional_insert_delete_array.sv
// Top level of the positional insert/delete list: joins the controller and
// the datapath. Depends on pida_pkg, pida_ctrl, pida_dp and pida_ram.
//
// Usage. Each request on the in_ channel carries a mode (insert, delete or
// read), a 1-based position and, for an insert, a value. A request is taken
// at a rising edge with in_valid high and in_stall low. Every request gives
// exactly one result on the out_ channel: a status (ok, list full, position
// out of range), the entry read or removed (zero otherwise) and the number
// of entries held afterwards. A result is taken at an edge with out_valid
// high and out_stall low.
//
// Entry moves. The entries live in a single-port-write RAM with a
// registered read, and every entry that moves is read and then written
// back one place over. One request is worked on at a time: the block
// takes no new request until the result of the last one has gone into
// the result register.
//
// Reset (rst_n, synchronous, active low) empties the list and drops any
// pending result; the RAM itself is not cleared since no entry at or above
// the count is ever read. While the receiver stalls, the result register
// holds its contents; the block still takes and works the next request and
// waits with its result until the register is free.
`default_nettype none

module positional_insert_delete_array (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [pida_pkg::MODE_W-1:0]        in_mode,
  input  wire logic [pida_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [pida_pkg::DATA_W-1:0] in_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [pida_pkg::STAT_W-1:0]             out_status,
  output logic signed [pida_pkg::DATA_W-1:0]      out_read_value,
  output logic [pida_pkg::CNT_W-1:0]              out_count
);

  import pida_pkg::*;

  // Command and status bundles between the state machine and the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences each request and holds the input stall.
  pida_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the list, the count and the result register.
  pida_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

endmodule

`default_nettype wire

### rtl/core/pida_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module pida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/pida_dp.sv
// Datapath of the positional insert/delete list: request registers, entry
// count, move pointer, entry RAM and the result register.
// Depends on pida_pkg and pida_ram.
`default_nettype none

module pida_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pida_pkg::dp_cmd_t              cmd,
  output pida_pkg::dp_stat_t                  stat,
  input  wire logic [pida_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [pida_pkg::POS_W-1:0]     in_position,
  input  wire logic signed [pida_pkg::DATA_W-1:0] in_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pida_pkg::STAT_W-1:0]         out_status,
  output logic signed [pida_pkg::DATA_W-1:0]  out_read_value,
  output logic [pida_pkg::CNT_W-1:0]          out_count
);

  import pida_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [STAT_W-1:0] status_r;
  logic [DATA_W-1:0] rv_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  ptr_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [DATA_W-1:0] out_rv_r;
  logic [CNT_W-1:0]  out_count_r;

  logic [POS_W-1:0]  idx;
  logic [POS_W:0]    pos_ext;
  logic [CNT_W:0]    cnt_ext;
  logic [STAT_W-1:0] res_status;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign idx     = pos_r - POS_W'(1);
  assign pos_ext = {1'b0, pos_r};
  assign cnt_ext = {1'b0, count_r};

  // Checks in the model's order: full list first, then position range.
  always_comb begin
    res_status = STAT_OK;
    if (mode_r == MODE_INSERT) begin
      if (count_r == CNT_W'(DEPTH)) begin
        res_status = STAT_FULL;
      end else if (pos_r == '0 || pos_ext > (cnt_ext + (CNT_W+1)'(1))) begin
        res_status = STAT_RANGE;
      end
    end else if (mode_r == MODE_DELETE || mode_r == MODE_READ) begin
      if (pos_r == '0 || pos_ext > cnt_ext) begin
        res_status = STAT_RANGE;
      end
    end else begin
      res_status = STAT_RANGE;
    end
  end

  always_comb begin
    stat.err           = (res_status != STAT_OK);
    stat.is_insert     = (mode_r == MODE_INSERT);
    stat.is_delete     = (mode_r == MODE_DELETE);
    stat.ins_no_shift  = (count_r == CNT_W'(idx));
    stat.ins_last      = ((ptr_r - CNT_W'(1)) == CNT_W'(idx));
    stat.del_more      = ((ptr_r + CNT_W'(1)) < count_r);
    stat.del_more_next = ((ptr_r + CNT_W'(2)) < count_r);
    stat.out_free      = !out_valid_r || !out_stall;
  end

  // RAM ports: a shift step writes the word read in the step before.
  assign ram_we    = cmd.wr_shift || cmd.wr_value;
  assign ram_waddr = cmd.wr_value ? ADDR_W'(idx) : ADDR_W'(ptr_r);
  assign ram_wdata = cmd.wr_value ? val_r : ram_rdata;

  always_comb begin
    priority if (cmd.rd_prev) begin
      ram_raddr = ADDR_W'(ptr_r - CNT_W'(1));
    end else if (cmd.rd_next) begin
      ram_raddr = ADDR_W'(ptr_r + CNT_W'(1));
    end else begin
      ram_raddr = ADDR_W'(idx);
    end
  end

  pida_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_value;
    end
    if (cmd.decide) begin
      status_r <= res_status;
    end
    if (cmd.load) begin
      rv_r <= '0;
    end else if (cmd.cap_rv) begin
      rv_r <= ram_rdata;
    end
    priority if (cmd.ptr_from_count) begin
      ptr_r <= count_r;
    end else if (cmd.ptr_from_idx) begin
      ptr_r <= CNT_W'(idx);
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_r - CNT_W'(1);
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + CNT_W'(1);
    end
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_rv_r     <= rv_r;
      out_count_r  <= count_r;
    end
  end

  // Control state: entry count and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      priority if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rv_r;
  assign out_count      = out_count_r;

endmodule

`default_nettype wire

### rtl/core/pida_ctrl.sv
// Controller state machine of the positional insert/delete list: sequences
// the checks, the entry moves and the result hand-off. Depends on pida_pkg.
`default_nettype none

module pida_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output pida_pkg::dp_cmd_t       cmd,
  input  wire pida_pkg::dp_stat_t stat
);

  import pida_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_I_RD,
    S_I_WR,
    S_I_FIN,
    S_R_RD,
    S_R_CAP,
    S_D_RD,
    S_D_WR,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (stat.err) begin
          state_nxt = S_DONE;
        end else if (stat.is_insert && stat.ins_no_shift) begin
          state_nxt = S_I_FIN;
        end else if (stat.is_insert) begin
          cmd.ptr_from_count = 1'b1;
          state_nxt          = S_I_RD;
        end else begin
          cmd.ptr_from_idx = 1'b1;
          state_nxt        = S_R_RD;
        end
      end
      S_I_RD: begin
        cmd.rd_prev = 1'b1;
        state_nxt   = S_I_WR;
      end
      S_I_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_dec  = 1'b1;
        state_nxt    = stat.ins_last ? S_I_FIN : S_I_RD;
      end
      S_I_FIN: begin
        cmd.wr_value = 1'b1;
        cmd.cnt_inc  = 1'b1;
        state_nxt    = S_DONE;
      end
      S_R_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_R_CAP;
      end
      S_R_CAP: begin
        cmd.cap_rv = 1'b1;
        priority if (!stat.is_delete) begin
          state_nxt = S_DONE;
        end else if (stat.del_more) begin
          state_nxt = S_D_RD;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_D_RD: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_D_WR;
      end
      S_D_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_inc  = 1'b1;
        if (stat.del_more_next) begin
          state_nxt = S_D_RD;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

### dv/positional_insert_delete_array_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for positional_insert_delete_array: a directed table of
// requests, then phased random traffic, every result checked against a model
// of the list kept inside the bench. Depends on pida_pkg and the RTL top level.

module positional_insert_delete_array_tb;
  import pida_pkg::*;

  // The mode field has one code that no operation uses.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int NUM_PROBES      = 25;
  localparam int IDLE_PCT        = 12;
  localparam int NOISE_PCT       = 8;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int STEADY_FROM     = 1000;
  localparam int STEADY_TO       = 1250;
  localparam int CHURN_REQUESTS  = 200;
  // The slowest request is a delete at the head of a full list; this
  // covers any work still in flight at the end.
  localparam int DRAIN_CYCLES    = 300;
  // Longest quiet stretch: the receiver hold-off plus one slow request.
  localparam int WATCHDOG_LIMIT  = 4000;

  // One result as it appears on the out_ channel.
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         entries_held;
  } result_t;

  // One row of the directed table. Where typed is set, the expected result
  // is the one written in the row; otherwise the list model supplies it.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    result_t                  want;
  } probe_t;

  // Traffic shapes of the random part: fill the list until it overflows,
  // drain it until it underflows, then a balanced mix.
  typedef enum logic [1:0] {GROW, SHRINK, CHURN} traffic_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_read_value;
  logic [CNT_W-1:0]         out_count;

  // Model of the list: entries below list_len are always written ones.
  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int                       list_len;

  result_t expected_results [$];
  int      mismatches   = 0;
  int      quiet_cycles = 0;
  int      random_sent  = 0;
  bit      steady       = 1'b0;

  // Directed requests. The list goes empty -> [-1, 5a5a5a5a, min, max] and
  // back to empty, touching the value extremes, every operation, positions
  // 0, count, count+1 and 255, and the unused mode.
  probe_t probe_table [NUM_PROBES] = '{
    '{MODE_READ,   8'd1,   32'sd0,            1'b1, '{STAT_RANGE, 32'sd0, 8'd0}},
    '{MODE_DELETE, 8'd1,   32'sd0,            1'b1, '{STAT_RANGE, 32'sd0, 8'd0}},
    '{MODE_INSERT, 8'd0,   32'sd1,            1'b1, '{STAT_RANGE, 32'sd0, 8'd0}},
    '{MODE_INSERT, 8'd2,   32'sd2,            1'b1, '{STAT_RANGE, 32'sd0, 8'd0}},
    '{MODE_INSERT, 8'd1,   32'sh8000_0000,    1'b1, '{STAT_OK,    32'sd0, 8'd1}},
    '{MODE_INSERT, 8'd2,   32'sh7fff_ffff,    1'b1, '{STAT_OK,    32'sd0, 8'd2}},
    '{MODE_INSERT, 8'd1,   32'shffff_ffff,    1'b1, '{STAT_OK,    32'sd0, 8'd3}},
    '{MODE_INSERT, 8'd2,   32'sh5a5a_5a5a,    1'b1, '{STAT_OK,    32'sd0, 8'd4}},
    '{MODE_READ,   8'd1,   32'sh1234_5678,    1'b0, result_t'(0)},
    '{MODE_READ,   8'd4,   32'sd0,            1'b0, result_t'(0)},
    '{MODE_READ,   8'd5,   32'sd0,            1'b1, '{STAT_RANGE, 32'sd0, 8'd4}},
    '{MODE_READ,   8'd0,   32'sd0,            1'b1, '{STAT_RANGE, 32'sd0, 8'd4}},
    '{MODE_UNUSED, 8'd1,   32'sd7,            1'b1, '{STAT_RANGE, 32'sd0, 8'd4}},
    '{MODE_INSERT, 8'd255, 32'sd9,            1'b1, '{STAT_RANGE, 32'sd0, 8'd4}},
    '{MODE_DELETE, 8'd255, 32'sd0,            1'b1, '{STAT_RANGE, 32'sd0, 8'd4}},
    '{MODE_DELETE, 8'd2,   32'sd0,            1'b0, result_t'(0)},
    '{MODE_DELETE, 8'd3,   32'sd0,            1'b0, result_t'(0)},
    '{MODE_DELETE, 8'd3,   32'sd0,            1'b1, '{STAT_RANGE, 32'sd0, 8'd2}},
    '{MODE_INSERT, 8'd3,   32'sh1234_5678,    1'b1, '{STAT_OK,    32'sd0, 8'd3}},
    '{MODE_READ,   8'd2,   32'sd0,            1'b0, result_t'(0)},
    '{MODE_DELETE, 8'd1,   32'sd0,            1'b0, result_t'(0)},
    '{MODE_DELETE, 8'd0,   32'sd0,            1'b1, '{STAT_RANGE, 32'sd0, 8'd2}},
    '{MODE_DELETE, 8'd1,   32'sd0,            1'b0, result_t'(0)},
    '{MODE_DELETE, 8'd1,   32'sd0,            1'b0, result_t'(0)},
    '{MODE_READ,   8'd1,   32'sd0,            1'b1, '{STAT_RANGE, 32'sd0, 8'd0}}
  };

  positional_insert_delete_array dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one accepted request to the list model and returns the result
  // the block must give for it. The full check comes before the position
  // check on an insert; a flagged request leaves the list as it was.
  task automatic apply_to_list(input logic [MODE_W-1:0] mode,
                               input logic [POS_W-1:0] position,
                               input logic signed [DATA_W-1:0] value,
                               output result_t res);
    int p;
    int i;
    p = position;
    res = '0;
    res.status = STAT_OK;
    case (mode)
      MODE_INSERT: begin
        if (list_len >= DEPTH) begin
          res.status = STAT_FULL;
        end else if (p == 0 || p > list_len + 1) begin
          res.status = STAT_RANGE;
        end else begin
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i - 1];
          list_mem[p - 1] = value;
          list_len++;
        end
      end
      MODE_DELETE, MODE_READ: begin
        if (p == 0 || p > list_len) begin
          res.status = STAT_RANGE;
        end else begin
          res.read_value = list_mem[p - 1];
          if (mode == MODE_DELETE) begin
            for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
            list_len--;
          end
        end
      end
      default: begin
        res.status = STAT_RANGE;
      end
    endcase
    res.entries_held = CNT_W'(list_len);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one request, with a random idle cycle ahead of it, and waits for
  // the block to take it. The expectation is queued at the accepting edge,
  // so the model sees requests in exactly the order the block does.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [POS_W-1:0] position,
                              input logic signed [DATA_W-1:0] value,
                              input logic typed, input result_t typed_res);
    result_t predicted;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_position <= position;
    in_value    <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_to_list(mode, position, value, predicted);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Sender: reset, the directed table, then the random traffic.
  initial begin
    traffic_t                 phase;
    int                       phase_age;
    int                       stuck;
    int                       hi;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    list_len    = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mode     <= MODE_READ;
    in_position <= '0;
    in_value    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < NUM_PROBES; k++) begin
      send_request(probe_table[k].mode, probe_table[k].position, probe_table[k].value,
                   probe_table[k].typed, probe_table[k].want);
    end

    phase     = GROW;
    phase_age = 0;
    stuck     = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // A window with no idling on either side, so back-to-back requests
      // and results are seen too.
      steady = (n >= STEADY_FROM && n < STEADY_TO);
      value  = $urandom();
      if ($urandom_range(99) < NOISE_PCT) begin
        // Noise: any mode, any position, most of them flagged.
        mode     = MODE_W'($urandom_range(3));
        position = POS_W'($urandom_range(255));
      end else begin
        if (phase == GROW) begin
          mode = ($urandom_range(9) < 8) ? MODE_INSERT : MODE_READ;
        end else if (phase == SHRINK) begin
          mode = ($urandom_range(9) < 8) ? MODE_DELETE : MODE_READ;
        end else begin
          case ($urandom_range(2))
            0:       mode = MODE_INSERT;
            1:       mode = MODE_DELETE;
            default: mode = MODE_READ;
          endcase
        end
        // Legal positions run from 1 to count+1 for an insert and to count
        // otherwise; the ends of that span get extra weight. Inserts on a
        // full list and reads or deletes on an empty one are flagged.
        hi = (mode == MODE_INSERT) ? list_len + 1 : list_len;
        if (hi == 0) begin
          position = 8'd1;
        end else begin
          case ($urandom_range(3))
            0:       position = 8'd1;
            1:       position = POS_W'(hi);
            default: position = POS_W'($urandom_range(hi, 1));
          endcase
        end
      end
      send_request(mode, position, value, 1'b0, result_t'(0));
      random_sent = n + 1;

      // Move on once the list has overflowed or underflowed a few times, or the mix has run its length.
      phase_age++;
      if ((phase == GROW && list_len == DEPTH) || (phase == SHRINK && list_len == 0)) begin
        stuck++;
      end
      if ((phase == GROW && stuck >= 4) || (phase == SHRINK && stuck >= 4) ||
          (phase == CHURN && phase_age >= CHURN_REQUESTS)) begin
        case (phase)
          GROW:    phase = SHRINK;
          SHRINK:  phase = CHURN;
          default: phase = GROW;
        endcase
        stuck     = 0;
        phase_age = 0;
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // offering requests, so the block finishes its work, holds its result and
  // has to stall its input.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && random_sent >= HOLD_OFF_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Result checker: every accepted result is compared field by field with
  // the oldest outstanding expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding",
                        {out_status, out_read_value, out_count}, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          report_mismatch("status", out_status, want.status);
        end
        if (out_read_value !== want.read_value) begin
          report_mismatch("read_value", out_read_value, want.read_value);
        end
        if (out_count !== want.entries_held) begin
          report_mismatch("count", out_count, want.entries_held);
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### sim.f
rtl/core/pida_pkg.sv
rtl/core/pida_ram.sv
rtl/core/pida_dp.sv
rtl/core/pida_ctrl.sv
rtl/core/positional_insert_delete_array.sv
dv/positional_insert_delete_array_tb.sv
